// ===== sv/rtcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types and codes for the RTC calendar check and BCD pack block.
// ----------------------------------------------------------------------------
package rtcc_pkg;

	// item mode codes
	typedef enum logic [1:0] {
		MODE_TIME  = 2'd0,
		MODE_DATE  = 2'd1,
		MODE_BOTH  = 2'd2,
		MODE_ALARM = 2'd3
	} rtcc_mode_t;

	// range limits
	localparam logic [7:0] MinSecLimit = 8'd60;
	localparam logic [7:0] Hour24Limit = 8'd24;
	localparam logic [7:0] Hour12Max   = 8'd12;
	localparam logic [7:0] DayMax      = 8'd31;
	localparam logic [7:0] DayMaxFeb   = 8'd29;
	localparam logic [7:0] DayMax30    = 8'd30;
	localparam logic [7:0] MonthMax    = 8'd12;
	localparam logic [7:0] YearMax     = 8'd99;
	localparam logic [3:0] WeekdayMax  = 4'd7;
	localparam logic [3:0] DigitMax    = 4'd9;

	localparam int TimeWordW = 23;
	localparam int DateWordW = 24;

	// one decoded calendar field
	typedef struct packed {
		logic [7:0] value;      // numeric value
		logic [4:0] tens;       // tens digit (binary input may exceed 9)
		logic [3:0] units;      // units digit
		logic       bad_digit;  // BCD nibble above 9
	} rtcc_field_t;

	// one input item
	typedef struct packed {
		rtcc_mode_t mode;
		logic       is_bcd;
		logic [7:0] hour_value;
		logic [7:0] minute_value;
		logic [7:0] second_value;
		logic [7:0] day_value;
		logic [7:0] month_value;
		logic [7:0] year_value;
		logic [3:0] weekday;
		logic       format_24h;
		logic       afternoon;
	} rtcc_item_t;

	// one result item
	typedef struct packed {
		logic                 status;
		logic [TimeWordW-1:0] time_word;
		logic [DateWordW-1:0] date_word;
	} rtcc_result_t;

endpackage

// ===== sv/rtc_time_date_check_and_bcd_pack_top.sv =====
// ----------------------------------------------------------------------------
// rtc_time_date_check_and_bcd_pack_top
// RTC calendar checker and time/date register word packer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one calendar item: mode, is_bcd,
//   the six 8-bit calendar values, weekday, format_24h and afternoon.
//   Output channel (out_valid/out_ready) returns one result per item: status
//   (1 = some checked field out of range), time_word and date_word, both zero
//   when status is set.
//   The item lands in the input register at its transfer, the checks and
//   packing run in one combinational pass, and the result is then
//   registered in the output register once that register can take it.
//   Throughput is one item per cycle while out_ready stays high.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more item; in_ready drops only once both
//   registers are full.
//   Reset (arst_n low) empties both stages; no item or result survives it.
// ----------------------------------------------------------------------------
module rtc_time_date_check_and_bcd_pack_top import rtcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        is_bcd,
	input  logic [7:0]  hour_value,
	input  logic [7:0]  minute_value,
	input  logic [7:0]  second_value,
	input  logic [7:0]  day_value,
	input  logic [7:0]  month_value,
	input  logic [7:0]  year_value,
	input  logic [3:0]  weekday,
	input  logic        format_24h,
	input  logic        afternoon,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [22:0] time_word,
	output logic [23:0] date_word
);

	logic         valid_s1, valid_s2;
	logic         adv_s1;
	rtcc_item_t   item_s1;
	rtcc_result_t res_comb, res_s2;

	// stage control
	assign adv_s1   = ~valid_s2 | out_ready;
	assign in_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv_s1)   valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{mode: rtcc_mode_t'(mode), is_bcd: is_bcd,
				hour_value: hour_value, minute_value: minute_value,
				second_value: second_value, day_value: day_value,
				month_value: month_value, year_value: year_value,
				weekday: weekday, format_24h: format_24h, afternoon: afternoon};
		end
	end

	// check and pack
	rtcc_check u_check (.item(item_s1), .res(res_comb));

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign status    = res_s2.status;
	assign time_word = res_s2.time_word;
	assign date_word = res_s2.date_word;

endmodule

// ===== sv/rtcc_field.sv =====
// ----------------------------------------------------------------------------
// rtcc_field
// Decodes one 8-bit calendar field, binary or packed BCD, into value and digits.
// ----------------------------------------------------------------------------
module rtcc_field import rtcc_pkg::*; (
	input  logic [7:0]  raw,
	input  logic        is_bcd,
	output rtcc_field_t fld
);

	logic [15:0] prod;
	logic [4:0]  bin_tens;
	logic [7:0]  bin_tens10;
	logic [7:0]  bin_units;
	logic [7:0]  bcd_value;

	// binary: divide by ten through reciprocal 205/2048, exact for 8-bit values
	assign prod       = {8'd0, raw} * 16'd205;
	assign bin_tens   = prod[15:11];
	assign bin_tens10 = {bin_tens, 3'b000} + {2'b00, bin_tens, 1'b0};
	assign bin_units  = raw - bin_tens10;

	// BCD: tens*10 + units
	assign bcd_value = {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0}
		+ {4'd0, raw[3:0]};

	always_comb begin
		if (is_bcd) begin
			fld.value     = bcd_value;
			fld.tens      = {1'b0, raw[7:4]};
			fld.units     = raw[3:0];
			fld.bad_digit = (raw[7:4] > DigitMax) || (raw[3:0] > DigitMax);
		end else begin
			fld.value     = raw;
			fld.tens      = bin_tens;
			fld.units     = bin_units[3:0];
			fld.bad_digit = 1'b0;
		end
	end

endmodule

// ===== sv/rtcc_check.sv =====
// ----------------------------------------------------------------------------
// rtcc_check
// Range checks one calendar item and packs the RTC time and date words.
// ----------------------------------------------------------------------------
module rtcc_check import rtcc_pkg::*; (
	input  rtcc_item_t   item,
	output rtcc_result_t res
);

	rtcc_field_t hr, mn, sc, dy, mo, yr;

	logic sel_time, sel_date, sel_day;
	logic bad_time, bad_day, bad_date, bad;
	logic month_30;
	logic [TimeWordW-1:0] tw;
	logic [DateWordW-1:0] dw;

	// field decoders
	rtcc_field u_hr (.raw(item.hour_value),   .is_bcd(item.is_bcd), .fld(hr));
	rtcc_field u_mn (.raw(item.minute_value), .is_bcd(item.is_bcd), .fld(mn));
	rtcc_field u_sc (.raw(item.second_value), .is_bcd(item.is_bcd), .fld(sc));
	rtcc_field u_dy (.raw(item.day_value),    .is_bcd(item.is_bcd), .fld(dy));
	rtcc_field u_mo (.raw(item.month_value),  .is_bcd(item.is_bcd), .fld(mo));
	rtcc_field u_yr (.raw(item.year_value),   .is_bcd(item.is_bcd), .fld(yr));

	// which groups the mode checks
	always_comb begin
		case (item.mode)
			MODE_TIME: begin
				sel_time = 1'b1; sel_date = 1'b0; sel_day = 1'b0;
			end
			MODE_DATE: begin
				sel_time = 1'b0; sel_date = 1'b1; sel_day = 1'b1;
			end
			MODE_BOTH: begin
				sel_time = 1'b1; sel_date = 1'b1; sel_day = 1'b1;
			end
			MODE_ALARM: begin
				sel_time = 1'b1; sel_date = 1'b0; sel_day = 1'b1;
			end
			default: begin
				sel_time = 1'b0; sel_date = 1'b0; sel_day = 1'b0;
			end
		endcase
	end

	// time checks; hour 0 is accepted in 12h form
	assign bad_time = hr.bad_digit || mn.bad_digit || sc.bad_digit
		|| (mn.value >= MinSecLimit) || (sc.value >= MinSecLimit)
		|| (item.format_24h ? (hr.value >= Hour24Limit) : (hr.value > Hour12Max));

	// day of month and weekday
	assign bad_day = dy.bad_digit || (item.weekday > WeekdayMax) || (dy.value > DayMax);

	// month, year and month length
	assign month_30 = (mo.value == 8'd4) || (mo.value == 8'd6)
		|| (mo.value == 8'd9) || (mo.value == 8'd11);
	assign bad_date = mo.bad_digit || yr.bad_digit
		|| (mo.value > MonthMax) || (yr.value > YearMax)
		|| ((mo.value == 8'd2) && (dy.value > DayMaxFeb))
		|| (month_30 && (dy.value > DayMax30));

	assign bad = (sel_time && bad_time) || (sel_day && bad_day) || (sel_date && bad_date);

	// pack words; digit fields fit their slots whenever the item is valid
	always_comb begin
		tw = '0;
		dw = '0;
		if (sel_time) begin
			tw = {item.afternoon & ~item.format_24h, hr.tens[1:0], hr.units,
				1'b0, mn.tens[2:0], mn.units, 1'b0, sc.tens[2:0], sc.units};
		end
		if (sel_day) begin
			dw[3:0]   = dy.units;
			dw[5:4]   = dy.tens[1:0];
			dw[15:13] = item.weekday[2:0];
		end
		if (sel_date) begin
			dw[11:8]  = mo.units;
			dw[12]    = mo.tens[0];
			dw[19:16] = yr.units;
			dw[23:20] = yr.tens[3:0];
		end
	end

	assign res.status    = bad;
	assign res.time_word = bad ? '0 : tw;
	assign res.date_word = bad ? '0 : dw;

endmodule

// ===== test/tb_rtc_time_date_check_and_bcd_pack_top.sv =====
// ----------------------------------------------------------------------------
// tb_rtc_time_date_check_and_bcd_pack_top
// Self-checking bench for the RTC calendar check and BCD pack block.
// A queue-fed driver sends directed calendar items and then random ones,
// mostly well formed with single-field corruptions, plus some noise.
// A monitor compares every result with a local predictor, in order, while
// both channels stall at random.
// ----------------------------------------------------------------------------
module tb_rtc_time_date_check_and_bcd_pack_top import rtcc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 3000;

	typedef struct {
		rtcc_item_t item;
		int         gap;
	} send_slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic        is_bcd = 1'b0;
	logic [7:0]  hour_value = '0;
	logic [7:0]  minute_value = '0;
	logic [7:0]  second_value = '0;
	logic [7:0]  day_value = '0;
	logic [7:0]  month_value = '0;
	logic [7:0]  year_value = '0;
	logic [3:0]  weekday = '0;
	logic        format_24h = 1'b0;
	logic        afternoon = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        status;
	logic [22:0] time_word;
	logic [23:0] date_word;

	send_slot_t   pending_items[$];
	rtcc_result_t expected_results[$];
	rtcc_item_t   on_bus;
	int           wait_count = 0;
	int           stall_left = 0;
	int           result_count = 0;
	int           error_count = 0;
	int           idle_cycles = 0;

	rtc_time_date_check_and_bcd_pack_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.is_bcd       (is_bcd),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value),
		.day_value    (day_value),
		.month_value  (month_value),
		.year_value   (year_value),
		.weekday      (weekday),
		.format_24h   (format_24h),
		.afternoon    (afternoon),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.time_word    (time_word),
		.date_word    (date_word)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] to_bcd(int v);
		return {4'((v / 10) % 16), 4'(v % 10)};
	endfunction

	// numeric value and digits of one field; flags bad BCD nibbles
	function automatic int split_field(logic [7:0] raw, logic bcd, output int tens,
			output int units, output logic bad_digit);
		bad_digit = 1'b0;
		if (bcd) begin
			tens = raw[7:4];
			units = raw[3:0];
			bad_digit = (raw[7:4] > DigitMax) || (raw[3:0] > DigitMax);
			return tens * 10 + units;
		end
		tens = raw / 10;
		units = raw % 10;
		return raw;
	endfunction

	// expected status and packed words for one calendar item
	function automatic rtcc_result_t pack_calendar(rtcc_item_t it);
		rtcc_result_t r;
		logic chk_time, chk_date, chk_day, bad, bd;
		int hr, mn, sc, dy, mo, yr;
		int ht, hu, mnt, mnu, st, su, dt, du, mt, mu, yt, yu;
		logic [31:0] tw, dw;
		bad = 1'b0;
		tw = '0;
		dw = '0;
		chk_time = (it.mode != MODE_DATE);
		chk_date = (it.mode == MODE_DATE) || (it.mode == MODE_BOTH);
		chk_day = chk_date || (it.mode == MODE_ALARM);
		if (chk_time) begin
			hr = split_field(it.hour_value, it.is_bcd, ht, hu, bd);
			bad |= bd;
			mn = split_field(it.minute_value, it.is_bcd, mnt, mnu, bd);
			bad |= bd;
			sc = split_field(it.second_value, it.is_bcd, st, su, bd);
			bad |= bd;
			if (mn >= MinSecLimit || sc >= MinSecLimit) bad = 1'b1;
			if (it.format_24h ? (hr >= Hour24Limit) : (hr > Hour12Max)) bad = 1'b1;
			if (!bad) begin
				tw = su | (st << 4) | (mnu << 8) | (mnt << 12) | (hu << 16) | (ht << 20);
				// PM only in 12h form
				if (!it.format_24h && it.afternoon) tw[22] = 1'b1;
			end
		end
		if (chk_day) begin
			dy = split_field(it.day_value, it.is_bcd, dt, du, bd);
			bad |= bd;
			if (it.weekday > WeekdayMax || dy > DayMax) bad = 1'b1;
			dw = du | ((dt & 3) << 4) | ((it.weekday & 7) << 13);
			if (chk_date) begin
				mo = split_field(it.month_value, it.is_bcd, mt, mu, bd);
				bad |= bd;
				yr = split_field(it.year_value, it.is_bcd, yt, yu, bd);
				bad |= bd;
				if (mo > MonthMax || yr > YearMax) bad = 1'b1;
				if (mo == 2 && dy > DayMaxFeb) bad = 1'b1;
				if ((mo == 4 || mo == 6 || mo == 9 || mo == 11) && dy > DayMax30) bad = 1'b1;
				dw |= (mu << 8) | ((mt & 1) << 12) | (yu << 16) | (yt << 20);
			end
		end
		if (bad) begin
			tw = '0;
			dw = '0;
		end
		r.status = bad;
		r.time_word = tw[22:0];
		r.date_word = dw[23:0];
		return r;
	endfunction

	function automatic rtcc_item_t cal_item(rtcc_mode_t m, logic bcd, logic [7:0] h,
			logic [7:0] mi, logic [7:0] s, logic [7:0] d, logic [7:0] mo, logic [7:0] y,
			logic [3:0] wd, logic f24, logic pm);
		rtcc_item_t it;
		it.mode = m;
		it.is_bcd = bcd;
		it.hour_value = h;
		it.minute_value = mi;
		it.second_value = s;
		it.day_value = d;
		it.month_value = mo;
		it.year_value = y;
		it.weekday = wd;
		it.format_24h = f24;
		it.afternoon = pm;
		return it;
	endfunction

	// random item: mostly legal calendars, some with one field pushed out of range
	function automatic rtcc_item_t rand_item();
		rtcc_item_t it;
		int nums[6];
		logic [7:0] vals[6];
		int lim, k, j;
		logic [3:0] nib;
		it.mode = rtcc_mode_t'(2'($urandom_range(0, 3)));
		it.is_bcd = 1'($urandom_range(0, 1));
		it.format_24h = 1'($urandom_range(0, 1));
		it.afternoon = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 2) begin
			it.hour_value = 8'($urandom_range(0, 255));
			it.minute_value = 8'($urandom_range(0, 255));
			it.second_value = 8'($urandom_range(0, 255));
			it.day_value = 8'($urandom_range(0, 255));
			it.month_value = 8'($urandom_range(0, 255));
			it.year_value = 8'($urandom_range(0, 255));
			it.weekday = 4'($urandom_range(0, 15));
			return it;
		end
		nums[0] = it.format_24h ? $urandom_range(0, 23) : $urandom_range(0, 12);
		nums[1] = $urandom_range(0, 59);
		nums[2] = $urandom_range(0, 59);
		nums[4] = $urandom_range(0, 12);
		lim = (nums[4] == 2) ? 29 :
			(nums[4] == 4 || nums[4] == 6 || nums[4] == 9 || nums[4] == 11) ? 30 : 31;
		nums[3] = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(0, lim);
		nums[5] = $urandom_range(0, 99);
		it.weekday = 4'($urandom_range(0, 7));
		k = $urandom_range(0, 11);
		case (k)
			0: nums[0] = it.format_24h ? $urandom_range(24, 31) : $urandom_range(13, 23);
			1: nums[1] = $urandom_range(60, 99);
			2: nums[2] = $urandom_range(60, 99);
			3: nums[3] = lim + 1;
			4: nums[4] = $urandom_range(13, 19);
			5: nums[5] = $urandom_range(100, 255);
			6: it.weekday = 4'($urandom_range(8, 15));
			default: ;
		endcase
		for (int i = 0; i < 6; i++) begin
			vals[i] = it.is_bcd ? to_bcd(nums[i]) : 8'(nums[i]);
		end
		// a nibble above nine in one BCD field
		if (k == 7 && it.is_bcd) begin
			j = $urandom_range(0, 5);
			nib = 4'($urandom_range(10, 15));
			if ($urandom_range(0, 1)) vals[j][7:4] = nib;
			else vals[j][3:0] = nib;
		end
		it.hour_value = vals[0];
		it.minute_value = vals[1];
		it.second_value = vals[2];
		it.day_value = vals[3];
		it.month_value = vals[4];
		it.year_value = vals[5];
		return it;
	endfunction

	task automatic post_item(rtcc_item_t it, bit no_gap);
		send_slot_t slot;
		slot.item = it;
		slot.gap = no_gap ? 0 : pick_gap();
		pending_items.push_back(slot);
	endtask

	task automatic flag_error(string what);
		$display("ERROR: %s", what);
		error_count++;
	endtask

	// hold the sender until everything sent has come back
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// input side: record each transfer, then present the next queued item
	always @(posedge clk) begin : send_side
		send_slot_t slot;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) expected_results.push_back(pack_calendar(on_bus));
			if (!in_valid || in_ready) begin
				if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (wait_count < pending_items[0].gap) begin
					wait_count++;
					in_valid <= 1'b0;
				end else begin
					slot = pending_items.pop_front();
					on_bus = slot.item;
					wait_count = 0;
					mode <= slot.item.mode;
					is_bcd <= slot.item.is_bcd;
					hour_value <= slot.item.hour_value;
					minute_value <= slot.item.minute_value;
					second_value <= slot.item.second_value;
					day_value <= slot.item.day_value;
					month_value <= slot.item.month_value;
					year_value <= slot.item.year_value;
					weekday <= slot.item.weekday;
					format_24h <= slot.item.format_24h;
					afternoon <= slot.item.afternoon;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// output side: check each transfer against the oldest expectation
	always @(posedge clk) begin : recv_side
		rtcc_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("result %0d with nothing outstanding", result_count));
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						flag_error($sformatf("result %0d status %b, want %b",
							result_count, status, want.status));
					if (time_word !== want.time_word)
						flag_error($sformatf("result %0d time_word %06h, want %06h",
							result_count, time_word, want.time_word));
					if (date_word !== want.date_word)
						flag_error($sformatf("result %0d date_word %06h, want %06h",
							result_count, date_word, want.date_word));
				end
				result_count++;
			end
			// no stalls for a stretch in the middle of the run
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!(result_count >= 400 && result_count < 600) && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// time checks, 24h and 12h
		post_item(cal_item(MODE_TIME, 0, 23, 59, 59, 255, 255, 255, 15, 1, 1), 0);
		post_item(cal_item(MODE_TIME, 0, 24, 0, 0, 1, 1, 1, 1, 1, 0), 0);
		post_item(cal_item(MODE_TIME, 0, 12, 59, 59, 1, 1, 1, 1, 0, 1), 0);
		post_item(cal_item(MODE_TIME, 0, 13, 0, 0, 1, 1, 1, 1, 0, 0), 0);
		post_item(cal_item(MODE_TIME, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0), 0);
		post_item(cal_item(MODE_TIME, 0, 60, 60, 0, 1, 1, 1, 1, 1, 0), 0);
		post_item(cal_item(MODE_TIME, 0, 5, 10, 60, 1, 1, 1, 1, 1, 0), 0);
		// date checks, month lengths and limits
		post_item(cal_item(MODE_DATE, 0, 255, 255, 255, 31, 12, 99, 7, 0, 1), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 29, 2, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 30, 2, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 31, 4, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 31, 11, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 30, 11, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 0, 0, 0, 0, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 15, 13, 24, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 15, 6, 100, 3, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 0, 1, 1, 1, 15, 6, 24, 8, 1, 0), 0);
		// BCD forms and bad digits
		post_item(cal_item(MODE_BOTH, 1, 8'h23, 8'h59, 8'h59, 8'h31, 8'h12, 8'h99, 7, 1, 0), 0);
		post_item(cal_item(MODE_TIME, 1, 8'h11, 8'h1A, 8'h00, 8'hFF, 8'hFF, 8'hFF, 0, 0, 1), 0);
		post_item(cal_item(MODE_TIME, 1, 8'hA0, 8'h00, 8'h00, 1, 1, 1, 0, 1, 0), 0);
		post_item(cal_item(MODE_DATE, 1, 8'hFF, 8'hFF, 8'hFF, 8'h3A, 8'h01, 8'h20, 2, 1, 0), 0);
		// alarm: month and year ignored, day and weekday checked
		post_item(cal_item(MODE_ALARM, 0, 7, 30, 0, 31, 255, 255, 5, 0, 1), 0);
		post_item(cal_item(MODE_ALARM, 0, 7, 30, 0, 32, 1, 1, 5, 0, 1), 0);
		post_item(cal_item(MODE_ALARM, 1, 8'h07, 8'h30, 8'h00, 8'h15, 8'hFF, 8'hFF, 9, 1, 0), 0);
		post_item(cal_item(MODE_BOTH, 0, 255, 255, 255, 255, 255, 255, 15, 1, 1), 0);
		wait_drained();

		// random, with sender and receiver gaps
		for (int i = 0; i < 500; i++) post_item(rand_item(), 0);
		wait_drained();
		// back-to-back stretch
		for (int i = 0; i < 150; i++) post_item(rand_item(), 1);
		for (int i = 0; i < 500; i++) post_item(rand_item(), 0);
		wait_drained();
		repeat (8) @(negedge clk);

		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
